@@ rtl/swxfs_pkg.sv @@
// ----------------------------------------------------------------------------
// swxfs_pkg
// Shared constants, types and helpers for the sliding-window frame sync.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swxfs_pkg;

    localparam int FRAME_LENGTH = 32;
    localparam int PTR_W        = $clog2(FRAME_LENGTH);
    localparam int BYTE_W       = 8;
    localparam int IDX_W        = 6;
    localparam int TDATA_W      = 16;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    typedef enum logic [1:0] {
        SEL_WPTR,
        SEL_NEXT,
        SEL_POS
    } addr_sel_t;

    typedef struct packed {
        logic      capture;
        logic      update;
        addr_sel_t addr_sel;
        logic      clr_k;
        logic      inc_k;
        logic      load_out;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic k_last;
        logic out_free;
    } status_t;

    // ring position a + b, both below FRAME_LENGTH
    function automatic ptr_t wrap_add(input ptr_t a, input ptr_t b);
        logic [PTR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (PTR_W+1)'(FRAME_LENGTH)) begin
            sum = sum - (PTR_W+1)'(FRAME_LENGTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/sliding_window_xor_frame_sync_core.sv @@
// ----------------------------------------------------------------------------
// sliding_window_xor_frame_sync_core
// Frame sync over a ring window of received bytes with XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one received byte per word in s_tdata[7:0].
//   cfg channel: header byte in cfg_data[7:0]; always ready, write only
//   while idle.
//   m_ channel: one frame byte per word, tdata = {byte_index, frame_byte},
//   m_tlast on the final byte of the frame.
// Each byte is captured, folded into the window, then checked. On a hit the
// whole window (FRAME_LENGTH words, header first) is read from the window
// RAM one word at a time: each word is read, then loaded into the output
// register once it is free; the single RAM read port sets this pace.
// s_tready is high only between bytes. The next byte is taken while the
// final word still sits in the output register.
// Reset: header byte 0x55, window, pointer and checksum clear at once
// (per-entry valid bits), no clearing pass.
// A stalled receiver holds the read-out; no word is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_xor_frame_sync_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [swxfs_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [swxfs_pkg::BYTE_W-1:0]  cfg_data,  // [7:0] header_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [swxfs_pkg::TDATA_W-1:0] m_tdata,   // [7:0] frame_byte, [13:8] byte_index
    output logic                               m_tlast
);

    import swxfs_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    swxfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swxfs_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/swxfs_ram.sv @@
// ----------------------------------------------------------------------------
// swxfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swxfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/swxfs_dp.sv @@
// ----------------------------------------------------------------------------
// swxfs_dp
// Datapath: window RAM, write pointer, running XOR, header register and
// the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swxfs_dp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [swxfs_pkg::BYTE_W-1:0]   s_tdata,
    input  wire logic                           cfg_valid,
    input  wire logic [swxfs_pkg::BYTE_W-1:0]   cfg_data,
    input  wire swxfs_pkg::cmd_t                cmd,
    output swxfs_pkg::status_t                  status,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [swxfs_pkg::TDATA_W-1:0]  m_tdata,
    output logic                                m_tlast
);

    import swxfs_pkg::*;

    logic [BYTE_W-1:0]       header_reg, header_next;
    logic [BYTE_W-1:0]       rx_reg, rx_next;
    ptr_t                    wptr_reg, wptr_next;
    logic [BYTE_W-1:0]       xor_reg, xor_next;
    ptr_t                    k_reg, k_next;
    logic [FRAME_LENGTH-1:0] valid_reg, valid_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]       out_byte_reg, out_byte_next;
    logic [IDX_W-1:0]        out_idx_reg, out_idx_next;
    logic                    out_last_reg, out_last_next;

    ptr_t              raddr;
    ptr_t              wptr_inc;
    ptr_t              pos;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] rd_byte;

    swxfs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_LENGTH)
    ) u_window (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (wptr_reg),
        .wdata (rx_reg),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // entries never written read as zero
    assign rd_byte  = rd_valid_reg ? ram_rdata : '0;
    assign wptr_inc = wrap_add(wptr_reg, PTR_W'(1));
    assign pos      = wrap_add(wptr_reg, k_reg);

    always_comb begin
        unique case (cmd.addr_sel)
            SEL_WPTR: raddr = wptr_reg;
            SEL_NEXT: raddr = wptr_inc;
            SEL_POS:  raddr = pos;
            default:  raddr = wptr_reg;
        endcase
    end

    always_comb begin
        header_next    = cfg_valid ? cfg_data : header_reg;
        rx_next        = cmd.capture ? s_tdata : rx_reg;
        wptr_next      = cmd.update ? wptr_inc : wptr_reg;
        xor_next       = cmd.update ? (xor_reg ^ rd_byte ^ rx_reg) : xor_reg;
        valid_next     = valid_reg;
        if (cmd.update) begin
            valid_next[wptr_reg] = 1'b1;
        end
        rd_valid_next  = valid_reg[raddr];
        k_next         = k_reg;
        if (cmd.clr_k) begin
            k_next = '0;
        end else if (cmd.inc_k) begin
            k_next = k_reg + PTR_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        out_byte_next  = cmd.load_out ? rd_byte : out_byte_reg;
        out_idx_next   = cmd.load_out ? IDX_W'(k_reg) : out_idx_reg;
        out_last_next  = cmd.load_out ? status.k_last : out_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg    <= HEADER_RESET;
            wptr_reg      <= '0;
            xor_reg       <= '0;
            k_reg         <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            header_reg    <= header_next;
            wptr_reg      <= wptr_next;
            xor_reg       <= xor_next;
            k_reg         <= k_next;
            valid_reg     <= valid_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rx_reg       <= rx_next;
        out_byte_reg <= out_byte_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    assign status.match    = (rd_byte == header_reg) && (xor_reg == '0);
    assign status.k_last   = (k_reg == PTR_W'(FRAME_LENGTH - 1));
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({out_idx_reg, out_byte_reg});
    assign m_tlast  = out_last_reg;

    a_wptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, wptr_reg} < (PTR_W+1)'(FRAME_LENGTH))
        else $error("write pointer out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("pending word overwritten");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_last_reg) |-> (out_idx_reg == IDX_W'(FRAME_LENGTH - 1)))
        else $error("last word at wrong index");

endmodule

`default_nettype wire

@@ rtl/swxfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// swxfs_ctrl
// Controller: sequences window update, frame check and frame read-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swxfs_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire swxfs_pkg::status_t status,
    output swxfs_pkg::cmd_t         cmd
);

    import swxfs_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid) begin
                            state_next = ST_UPDATE;
                        end
            ST_UPDATE:  state_next = ST_CHECK;
            ST_CHECK:   state_next = status.match ? ST_EMIT_RD : ST_IDLE;
            ST_EMIT_RD: state_next = ST_EMIT_WR;
            ST_EMIT_WR: if (status.out_free) begin
                            state_next = status.k_last ? ST_IDLE : ST_EMIT_RD;
                        end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.addr_sel = SEL_WPTR;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_UPDATE: begin
                cmd.update   = 1'b1;
                cmd.addr_sel = SEL_NEXT;
            end
            ST_CHECK: begin
                cmd.clr_k = 1'b1;
            end
            ST_EMIT_RD: begin
                cmd.addr_sel = SEL_POS;
            end
            ST_EMIT_WR: begin
                cmd.addr_sel = SEL_POS;
                cmd.load_out = status.out_free;
                cmd.inc_k    = status.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
